[hdl/pvms_pkg.sv]
// Shared widths, types and constants for the saturating PCM voice mixer.
package pvms_pkg;

  localparam int SAMPLE_W = 8;
  localparam int GAIN_W   = 8;
  localparam int SCALED_W = SAMPLE_W + 1;
  localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
  localparam int SUM_W    = SCALED_W + 1;

  localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 8'h80;
  localparam logic signed [SAMPLE_W-1:0] ACC_MAX = 8'sd127;
  localparam logic signed [SAMPLE_W-1:0] ACC_MIN = -8'sd128;

  typedef logic [SAMPLE_W-1:0]        sample_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic signed [SAMPLE_W-1:0] acc_t;
  typedef logic signed [SCALED_W-1:0] scaled_t;

  typedef struct packed {
    sample_t sample_left;
    sample_t sample_right;
    logic    is_mono;
    gain_t   gain_left;
    gain_t   gain_right;
    logic    last_voice;
  } voice_t;

endpackage

[hdl/pvms_voice_if.sv]
// Valid/ready channel carrying one voice contribution item.
interface pvms_voice_if
  import pvms_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t sample_left;
  sample_t sample_right;
  logic    is_mono;
  gain_t   gain_left;
  gain_t   gain_right;
  logic    last_voice;

  modport source (
    output valid, sample_left, sample_right, is_mono, gain_left, gain_right, last_voice,
    input  ready
  );
  modport sink (
    input  valid, sample_left, sample_right, is_mono, gain_left, gain_right, last_voice,
    output ready
  );
endinterface

[hdl/pvms_frame_if.sv]
// Valid/ready channel carrying one mixed stereo frame item.
interface pvms_frame_if
  import pvms_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t mix_left;
  sample_t mix_right;

  modport source (output valid, mix_left, mix_right, input ready);
  modport sink (input valid, mix_left, mix_right, output ready);
endinterface

[hdl/pcm_voice_mix_saturate.sv]
// Top level: saturating mixer of 8-bit PCM voices into stereo frames.
// A last voice item's frame passes from the input register to the output register.
// One voice item per cycle unless a last voice meets a stalled full output; the accumulators are the only loop.
// An output register lets new voices enter while a finished frame waits.
// Reset (synchronous, active high) clears both accumulators to silence
// and empties the input and output registers.
module pcm_voice_mix_saturate
  import pvms_pkg::*;
(
  input  logic clk,
  input  logic rst,
  pvms_voice_if.sink   voice,
  pvms_frame_if.source frame
);

  logic    in_valid;
  voice_t  in_item;
  logic    advance;
  logic    emit;
  sample_t right_src;
  scaled_t scaled_left;
  scaled_t scaled_right;
  sample_t mix_left_next;
  sample_t mix_right_next;
  logic    out_valid;
  sample_t out_left;
  sample_t out_right;

  assign emit    = in_valid & in_item.last_voice;
  assign advance = in_valid & (~in_item.last_voice | ~out_valid | frame.ready);
  assign voice.ready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (voice.ready) begin
      in_valid <= voice.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (voice.ready && voice.valid) begin
      in_item <= '{sample_left:  voice.sample_left,
                   sample_right: voice.sample_right,
                   is_mono:      voice.is_mono,
                   gain_left:    voice.gain_left,
                   gain_right:   voice.gain_right,
                   last_voice:   voice.last_voice};
    end
  end

  assign right_src = in_item.is_mono ? in_item.sample_left : in_item.sample_right;

  pvms_scale u_scale_left (
    .sample (in_item.sample_left),
    .gain   (in_item.gain_left),
    .scaled (scaled_left)
  );

  pvms_scale u_scale_right (
    .sample (right_src),
    .gain   (in_item.gain_right),
    .scaled (scaled_right)
  );

  pvms_accum u_accum_left (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .clear   (in_item.last_voice),
    .scaled  (scaled_left),
    .mix     (mix_left_next)
  );

  pvms_accum u_accum_right (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .clear   (in_item.last_voice),
    .scaled  (scaled_right),
    .mix     (mix_right_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_left  <= mix_left_next;
      out_right <= mix_right_next;
    end
  end

  assign frame.valid     = out_valid;
  assign frame.mix_left  = out_left;
  assign frame.mix_right = out_right;

endmodule

[hdl/pvms_scale.sv]
// Centers an unsigned sample and scales it by gain/256, truncating toward zero.
module pvms_scale
  import pvms_pkg::*;
(
  input  sample_t sample,
  input  gain_t   gain,
  output scaled_t scaled
);

  acc_t                     centered;
  logic signed [PROD_W-1:0] prod;
  logic                     round_up;

  assign centered = acc_t'(sample ^ SIGN_FLIP);
  assign prod     = PROD_W'(centered) * PROD_W'($signed({1'b0, gain}));
  // arithmetic shift floors; bump negatives with a remainder back toward zero
  assign round_up = prod[PROD_W-1] & (|prod[GAIN_W-1:0]);
  assign scaled   = scaled_t'(prod[PROD_W-1:GAIN_W]) + scaled_t'({1'b0, round_up});

endmodule

[hdl/pvms_accum.sv]
// One side's running accumulator with clip to the signed byte range.
module pvms_accum
  import pvms_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  logic    clear,
  input  scaled_t scaled,
  output sample_t mix
);

  acc_t                    acc;
  acc_t                    acc_next;
  logic signed [SUM_W-1:0] sum;

  assign sum = SUM_W'(acc) + SUM_W'(scaled);

  always_comb begin
    if (sum > SUM_W'(ACC_MAX)) begin
      acc_next = ACC_MAX;
    end else if (sum < SUM_W'(ACC_MIN)) begin
      acc_next = ACC_MIN;
    end else begin
      acc_next = acc_t'(sum);
    end
  end

  assign mix = sample_t'(acc_next) ^ SIGN_FLIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (advance) begin
      acc <= clear ? acc_t'(0) : acc_next;
    end
  end

endmodule
